>>> sv/spring_damper_link_force_defines.svh
// assertion macros shared by the link force rtl
`ifndef SPRING_DAMPER_LINK_FORCE_DEFINES_SVH
`define SPRING_DAMPER_LINK_FORCE_DEFINES_SVH
`ifndef SYNTH
`define SDLF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdlf check failed");
`define SDLF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdlf check failed");
`else
`define SDLF_ASSERT_IMP(lbl, ante, cons)
`define SDLF_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/sdlf_pkg.sv
// types and constants of the link force pipeline
package sdlf_pkg;
  localparam int DW    = 32;  // component width
  localparam int L0W   = 31;  // rest length width
  localparam int SQW   = 64;  // squared distance width
  localparam int RW    = 32;  // root width
  localparam int DVW   = 62;  // dividend width, l0 * |delta|
  localparam int QW    = 31;  // quotient width, bounded by l0
  localparam int NCOMP = 3;
  localparam int CAPW  = 51;  // spring magnitude cap is 2^50

  localparam int IN_TDATA_W  = 224;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 96;
  localparam int OUT_TUSER_W = 2;

  localparam logic REG_STIFFNESS = 1'b0;
  localparam logic REG_DAMPING   = 1'b1;

  typedef enum logic [1:0] {
    ST_APPLIED    = 2'd0,
    ST_NO_CONTACT = 2'd1,
    ST_ZERO_DIST  = 2'd2,
    ST_SAT        = 2'd3
  } status_t;

  typedef logic [NCOMP-1:0][DW-1:0] vec_t;
  typedef logic [NCOMP-1:0][QW-1:0] quot_t;

  typedef struct packed {
    vec_t                       delta;
    vec_t                       vel;
    logic [NCOMP-1:0][DVW-1:0]  dvd;
    logic                       no_contact;
    logic                       zero_dist;
  } sq_tag_t;

  typedef struct packed {
    vec_t delta;
    vec_t vel;
    logic no_contact;
    logic zero_dist;
  } fc_tag_t;

  typedef struct packed {
    vec_t    frc;
    status_t status;
  } result_t;
endpackage

>>> sv/sdlf_sqrt.sv
// pipelined integer square root, one result bit per stage
module sdlf_sqrt (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [sdlf_pkg::SQW-1:0]  in_n,
  input  sdlf_pkg::sq_tag_t         in_tag,
  output logic                      out_valid,
  output logic [sdlf_pkg::RW-1:0]   out_root,
  output sdlf_pkg::sq_tag_t         out_tag
);
  localparam int SQW    = sdlf_pkg::SQW;
  localparam int STAGES = sdlf_pkg::RW;

  logic [STAGES-1:0]   vld_r;
  logic [SQW-1:0]      n_r   [STAGES];
  logic [SQW-1:0]      res_r [STAGES];
  sdlf_pkg::sq_tag_t   tag_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [SQW:0] BIT = (SQW+1)'(1) << (SQW - 2 - 2*i);
    logic              v_in;
    logic [SQW-1:0]    n_in;
    logic [SQW-1:0]    res_in;
    sdlf_pkg::sq_tag_t t_in;
    logic [SQW:0]      trial;
    logic [SQW-1:0]    n_nxt;
    logic [SQW-1:0]    res_nxt;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign n_in   = in_n;
      assign res_in = '0;
      assign t_in   = in_tag;
    end else begin : g_rest
      assign v_in   = vld_r[i-1];
      assign n_in   = n_r[i-1];
      assign res_in = res_r[i-1];
      assign t_in   = tag_r[i-1];
    end

    assign trial = {1'b0, res_in} + BIT;

    always_comb begin
      if ({1'b0, n_in} >= trial) begin
        n_nxt   = n_in - trial[SQW-1:0];
        res_nxt = (res_in >> 1) + BIT[SQW-1:0];
      end else begin
        n_nxt   = n_in;
        res_nxt = res_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]   <= n_nxt;
        res_r[i] <= res_nxt;
        tag_r[i] <= t_in;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_root  = res_r[STAGES-1][sdlf_pkg::RW-1:0];
  assign out_tag   = tag_r[STAGES-1];
endmodule

>>> sv/sdlf_div.sv
// pipelined restoring divider, three lanes sharing the distance as divisor
module sdlf_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [sdlf_pkg::RW-1:0]  in_d,
  input  sdlf_pkg::sq_tag_t        in_tag,
  output logic                     out_valid,
  output sdlf_pkg::quot_t          out_quot,
  output sdlf_pkg::fc_tag_t        out_tag
);
  localparam int DVW    = sdlf_pkg::DVW;
  localparam int RW     = sdlf_pkg::RW;
  localparam int NCOMP  = sdlf_pkg::NCOMP;
  localparam int STAGES = sdlf_pkg::QW;

  logic [STAGES-1:0]               vld_r;
  logic [RW-1:0]                   d_r   [STAGES];
  logic [NCOMP-1:0][DVW-1:0]       rem_r [STAGES];
  sdlf_pkg::quot_t                 q_r   [STAGES];
  sdlf_pkg::fc_tag_t               tag_r [STAGES];

  sdlf_pkg::fc_tag_t first_tag;

  assign first_tag.delta      = in_tag.delta;
  assign first_tag.vel        = in_tag.vel;
  assign first_tag.no_contact = in_tag.no_contact;
  assign first_tag.zero_dist  = in_tag.zero_dist;

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    // this stage decides quotient bit SH
    localparam int SH = STAGES - 1 - i;
    logic                      v_in;
    logic [RW-1:0]             d_in;
    logic [NCOMP-1:0][DVW-1:0] rem_in;
    sdlf_pkg::quot_t           q_in;
    sdlf_pkg::fc_tag_t         t_in;
    logic [DVW-1:0]            dsh;
    logic [NCOMP-1:0][DVW-1:0] rem_nxt;
    sdlf_pkg::quot_t           q_nxt;

    if (i == 0) begin : g_first
      assign v_in   = in_valid;
      assign d_in   = in_d;
      assign rem_in = in_tag.dvd;
      assign q_in   = '0;
      assign t_in   = first_tag;
    end else begin : g_rest
      assign v_in   = vld_r[i-1];
      assign d_in   = d_r[i-1];
      assign rem_in = rem_r[i-1];
      assign q_in   = q_r[i-1];
      assign t_in   = tag_r[i-1];
    end

    assign dsh = {{(DVW-RW){1'b0}}, d_in} << SH;

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      for (int c = 0; c < NCOMP; c++) begin
        if (rem_in[c] >= dsh) begin
          rem_nxt[c]    = rem_in[c] - dsh;
          q_nxt[c][SH]  = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_r[i]   <= d_in;
        rem_r[i] <= rem_nxt;
        q_r[i]   <= q_nxt;
        tag_r[i] <= t_in;
      end
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_quot  = q_r[STAGES-1];
  assign out_tag   = tag_r[STAGES-1];
endmodule

>>> sv/sdlf_force.sv
// spring and damping products, sum, saturation and status, five stages
module sdlf_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  sdlf_pkg::quot_t          in_quot,
  input  sdlf_pkg::fc_tag_t        in_tag,
  input  logic [31:0]              stiffness,
  input  logic [31:0]              damping,
  output logic                     out_valid,
  output sdlf_pkg::result_t        out_res
);
  localparam int DW    = sdlf_pkg::DW;
  localparam int NCOMP = sdlf_pkg::NCOMP;
  localparam int CAPW  = sdlf_pkg::CAPW;
  localparam int TW    = 34;  // t = delta -/+ quotient
  localparam int PSW   = 65;  // 33 x 32 product
  localparam int PDW   = 64;  // 32 x 32 product
  localparam int FSW   = 66;  // force sum
  localparam logic [PSW-1:0]  CAP_P = PSW'(1) << (CAPW - 1);
  localparam logic [CAPW-1:0] CAP   = CAPW'(1) << (CAPW - 1);
  localparam logic signed [FSW-1:0] FMAX = FSW'(64'sd2147483647);
  localparam logic signed [FSW-1:0] FMIN = -FSW'(64'sd2147483648);

  logic [4:0] vld_r;

  // stage 1: t
  logic [NCOMP-1:0][TW-1:0] t_r;
  sdlf_pkg::vec_t           vel1_r;
  logic [1:0]               flg1_r;
  // stage 2: products
  logic [PSW-1:0]           ps_r [NCOMP];
  logic [PDW-1:0]           pd_r [NCOMP];
  logic [NCOMP-1:0]         st2_r, sv2_r;
  logic [1:0]               flg2_r;
  // stage 3: scaled magnitudes
  logic [CAPW-1:0]          sm_r [NCOMP];
  logic [PDW-1:0]           dm_r [NCOMP];
  logic [NCOMP-1:0]         st3_r, sv3_r;
  logic [1:0]               flg3_r;
  // stage 4: signed force
  logic signed [FSW-1:0]    f_r [NCOMP];
  logic [1:0]               flg4_r;
  // stage 5: result
  sdlf_pkg::result_t        res_r;

  logic [NCOMP-1:0][TW-1:0] t_nxt;
  logic [PSW-1:0]           ps_nxt [NCOMP];
  logic [PDW-1:0]           pd_nxt [NCOMP];
  logic [CAPW-1:0]          sm_nxt [NCOMP];
  logic [PDW-1:0]           dm_nxt [NCOMP];
  logic signed [FSW-1:0]    f_nxt  [NCOMP];
  sdlf_pkg::result_t        res_nxt;

  always_comb begin
    logic [TW-1:0]  dext;
    logic [TW-1:0]  qext;
    logic [TW-1:0]  tneg;
    logic [DW-1:0]  vneg;
    logic [PSW-1:0] sfull;
    logic [FSW-1:0] xs, yd, cin;
    logic           any_sat;
    for (int c = 0; c < NCOMP; c++) begin
      // truncating quotient: subtract its magnitude toward zero
      dext = {{(TW-DW){in_tag.delta[c][DW-1]}}, in_tag.delta[c]};
      qext = {{(TW-sdlf_pkg::QW){1'b0}}, in_quot[c]};
      t_nxt[c] = in_tag.delta[c][DW-1] ? dext + qext : dext - qext;

      tneg = t_r[c][TW-1] ? (~t_r[c] + TW'(1)) : t_r[c];
      vneg = vel1_r[c][DW-1] ? (~vel1_r[c] + DW'(1)) : vel1_r[c];
      ps_nxt[c] = PSW'(tneg[TW-2:0]) * PSW'(stiffness);
      pd_nxt[c] = PDW'(vneg) * PDW'(damping);

      sfull = ps_r[c] >> FRAC_BITS;
      sm_nxt[c] = (sfull > CAP_P) ? CAP : sfull[CAPW-1:0];
      dm_nxt[c] = pd_r[c] >> FRAC_BITS;

      // spring minus damping as one three-operand add
      xs  = st3_r[c] ? ~{{(FSW-CAPW){1'b0}}, sm_r[c]} : {{(FSW-CAPW){1'b0}}, sm_r[c]};
      yd  = sv3_r[c] ? {{(FSW-PDW){1'b0}}, dm_r[c]} : ~{{(FSW-PDW){1'b0}}, dm_r[c]};
      cin = FSW'(st3_r[c]) + FSW'(!sv3_r[c]);
      f_nxt[c] = $signed(xs + yd + cin);
    end

    any_sat = 1'b0;
    res_nxt.frc = '0;
    for (int c = 0; c < NCOMP; c++) begin
      if (f_r[c] > FMAX) begin
        res_nxt.frc[c] = 32'h7fff_ffff;
        any_sat = 1'b1;
      end else if (f_r[c] < FMIN) begin
        res_nxt.frc[c] = 32'h8000_0000;
        any_sat = 1'b1;
      end else begin
        res_nxt.frc[c] = f_r[c][DW-1:0];
      end
    end
    if (flg4_r[1]) begin
      res_nxt.frc    = '0;
      res_nxt.status = sdlf_pkg::ST_NO_CONTACT;
    end else if (flg4_r[0]) begin
      res_nxt.frc    = '0;
      res_nxt.status = sdlf_pkg::ST_ZERO_DIST;
    end else if (any_sat) begin
      res_nxt.status = sdlf_pkg::ST_SAT;
    end else begin
      res_nxt.status = sdlf_pkg::ST_APPLIED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      vel1_r <= in_tag.vel;
      flg1_r <= {in_tag.no_contact, in_tag.zero_dist};
      flg2_r <= flg1_r;
      flg3_r <= flg2_r;
      flg4_r <= flg3_r;
      for (int c = 0; c < NCOMP; c++) begin
        ps_r[c]  <= ps_nxt[c];
        pd_r[c]  <= pd_nxt[c];
        st2_r[c] <= t_r[c][TW-1];
        sv2_r[c] <= vel1_r[c][DW-1];
        sm_r[c]  <= sm_nxt[c];
        dm_r[c]  <= dm_nxt[c];
        f_r[c]   <= f_nxt[c];
      end
      st3_r <= st2_r;
      sv3_r <= sv2_r;
      res_r <= res_nxt;
    end
  end

  assign out_valid = vld_r[4];
  assign out_res   = res_r;
endmodule

>>> sv/spring_damper_link_force.sv
// top level: input stages, squared distance, root, divide, force, output buffer
//
//   port group   dir   contents
//   in_*         in    link item: deltas, velocity differences, rest length, opcode
//   out_*        out   force on the first particle and status
//   cfg_*        in    stiffness and damping writes
//
// one item per cycle while in_tready is high; an item passes through 4 input
// stages, the 32-stage square root, the 31-stage divider, 5 force stages and
// the output buffer, the first register loaded at the edge that takes the item
// rst_n is synchronous: clears all valid bits, the output buffer and the
// constants (stiffness 1.0, damping 0)
// a two-entry output buffer holds results; the whole pipeline holds only
// while both entries wait, so in_tready drops then and nothing is lost
`include "spring_damper_link_force_defines.svh"
module spring_damper_link_force #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // delta_x, delta_y, delta_z, rel_vel_x, rel_vel_y, rel_vel_z, rest_length, pad
  input  logic [sdlf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // opcode
  input  logic [sdlf_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // force_x, force_y, force_z
  output logic [sdlf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // status
  output logic [sdlf_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                              cfg_we,
  input  logic                              cfg_addr,
  input  logic [31:0]                       cfg_wdata
);
  localparam int DW    = sdlf_pkg::DW;
  localparam int L0W   = sdlf_pkg::L0W;
  localparam int SQW   = sdlf_pkg::SQW;
  localparam int DVW   = sdlf_pkg::DVW;
  localparam int NCOMP = sdlf_pkg::NCOMP;

  logic [31:0] stiff_r, damp_r;
  logic        en;

  // stage 0: input register
  logic             s0_vld_r;
  sdlf_pkg::vec_t   s0_delta_r, s0_vel_r;
  logic [L0W-1:0]   s0_l0_r;
  logic             s0_op_r;
  // stage 1: squares and dividends
  logic             s1_vld_r;
  logic [SQW-1:0]   s1_sq_r [NCOMP];
  logic [NCOMP-1:0][DVW-1:0] s1_dvd_r;
  logic [2*L0W-1:0] s1_l0sq_r;
  sdlf_pkg::vec_t   s1_delta_r, s1_vel_r;
  logic             s1_op_r;
  // stage 2: sum
  logic             s2_vld_r;
  logic [SQW-1:0]   s2_sum_r;
  logic [2*L0W-1:0] s2_l0sq_r;
  logic [NCOMP-1:0][DVW-1:0] s2_dvd_r;
  sdlf_pkg::vec_t   s2_delta_r, s2_vel_r;
  logic             s2_op_r;
  // stage 3: special cases
  logic             s3_vld_r;
  logic [SQW-1:0]   s3_sum_r;
  sdlf_pkg::sq_tag_t s3_tag_r;

  logic [SQW-1:0]   sq_nxt  [NCOMP];
  logic [NCOMP-1:0][DVW-1:0] dvd_nxt;
  sdlf_pkg::sq_tag_t tag_nxt;

  logic              rt_vld;
  logic [sdlf_pkg::RW-1:0] rt_root;
  sdlf_pkg::sq_tag_t rt_tag;
  logic              dv_vld;
  sdlf_pkg::quot_t   dv_quot;
  sdlf_pkg::fc_tag_t dv_tag;
  logic              fin_vld;
  sdlf_pkg::result_t fin_res;

  logic [1:0]        cnt_r, cnt_nxt;
  sdlf_pkg::result_t slot0_r, slot1_r;
  logic              push, pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stiff_r <= 32'd1 << FRAC_BITS;
      damp_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        sdlf_pkg::REG_STIFFNESS: stiff_r <= cfg_wdata;
        sdlf_pkg::REG_DAMPING:   damp_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  always_comb begin
    logic [DW-1:0]    mag;
    logic [DW+L0W-1:0] prod;
    for (int c = 0; c < NCOMP; c++) begin
      mag        = s0_delta_r[c][DW-1] ? (~s0_delta_r[c] + DW'(1)) : s0_delta_r[c];
      sq_nxt[c]  = SQW'(mag) * SQW'(mag);
      prod       = (DW+L0W)'(s0_l0_r) * (DW+L0W)'(mag);
      dvd_nxt[c] = prod[DVW-1:0];
    end
    tag_nxt.delta      = s2_delta_r;
    tag_nxt.vel        = s2_vel_r;
    tag_nxt.dvd        = s2_dvd_r;
    tag_nxt.no_contact = s2_op_r && (s2_sum_r > SQW'(s2_l0sq_r));
    tag_nxt.zero_dist  = (s2_sum_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_tvalid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_delta_r <= in_tdata[3*DW-1:0];
      s0_vel_r   <= in_tdata[6*DW-1:3*DW];
      s0_l0_r    <= in_tdata[6*DW+L0W-1:6*DW];
      s0_op_r    <= in_tuser[0];

      for (int c = 0; c < NCOMP; c++) begin
        s1_sq_r[c] <= sq_nxt[c];
      end
      s1_dvd_r   <= dvd_nxt;
      s1_l0sq_r  <= (2*L0W)'(s0_l0_r) * (2*L0W)'(s0_l0_r);
      s1_delta_r <= s0_delta_r;
      s1_vel_r   <= s0_vel_r;
      s1_op_r    <= s0_op_r;

      s2_sum_r   <= s1_sq_r[0] + s1_sq_r[1] + s1_sq_r[2];
      s2_l0sq_r  <= s1_l0sq_r;
      s2_dvd_r   <= s1_dvd_r;
      s2_delta_r <= s1_delta_r;
      s2_vel_r   <= s1_vel_r;
      s2_op_r    <= s1_op_r;

      s3_sum_r   <= s2_sum_r;
      s3_tag_r   <= tag_nxt;
    end
  end

  sdlf_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_vld_r),
    .in_n      (s3_sum_r),
    .in_tag    (s3_tag_r),
    .out_valid (rt_vld),
    .out_root  (rt_root),
    .out_tag   (rt_tag)
  );

  sdlf_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rt_vld),
    .in_d      (rt_root),
    .in_tag    (rt_tag),
    .out_valid (dv_vld),
    .out_quot  (dv_quot),
    .out_tag   (dv_tag)
  );

  sdlf_force #(
    .FRAC_BITS (FRAC_BITS)
  ) u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_vld),
    .in_quot   (dv_quot),
    .in_tag    (dv_tag),
    .stiffness (stiff_r),
    .damping   (damp_r),
    .out_valid (fin_vld),
    .out_res   (fin_res)
  );

  // two-entry output buffer, slot0 is the head
  assign push    = en && fin_vld;
  assign pop     = out_tvalid && out_tready;
  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        slot0_r <= slot1_r;
      end else if (push) begin
        slot0_r <= fin_res;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= fin_res;
      end else begin
        slot1_r <= fin_res;
      end
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = slot0_r.frc;
  assign out_tuser  = slot0_r.status;

  logic head_clamped;
  always_comb begin
    head_clamped = 1'b0;
    for (int c = 0; c < NCOMP; c++) begin
      if (slot0_r.frc[c] == 32'h7fff_ffff || slot0_r.frc[c] == 32'h8000_0000) begin
        head_clamped = 1'b1;
      end
    end
  end

  `SDLF_ASSERT_IMP(a_cnt_range, 1'b1, cnt_r != 2'd3)
  `SDLF_ASSERT_IMP(a_zero_dist_no_force, out_tvalid && out_tuser == sdlf_pkg::ST_ZERO_DIST, out_tdata == '0)
  `SDLF_ASSERT_IMP(a_no_contact_no_force, out_tvalid && out_tuser == sdlf_pkg::ST_NO_CONTACT, out_tdata == '0)
  `SDLF_ASSERT_IMP(a_sat_clamped, out_tvalid && out_tuser == sdlf_pkg::ST_SAT, head_clamped)
  `SDLF_ASSERT_NXT(a_drain_last, cnt_r == 2'd1 && pop && !push, !out_tvalid)
endmodule

>>> tb/tb_spring_damper_link_force.sv
// self-checking testbench for the spring damper link force pipeline
module tb_spring_damper_link_force;
  localparam int FRAC = 16;
  localparam int LATENCY = 80;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] dx, dy, dz, vx, vy, vz;
    logic [30:0] l0;
    logic        op;
  } link_t;

  typedef struct {
    logic [31:0]       fx, fy, fz;
    sdlf_pkg::status_t st;
  } force_t;

  class force_scoreboard;
    force_t pending[$];
    logic [31:0] k_q = 32'h0001_0000;
    logic [31:0] z_q = 32'h0;
    int errors = 0;
    int matched = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    function longint unsigned isqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function force_t link_force(link_t a);
      force_t r;
      longint signed dl[3], vl[3], q, t, f, sp, dp;
      longint unsigned sq, dlen, m, sm, dm, l0;
      logic [127:0] wide;
      logic sat;
      dl[0] = longint'($signed(a.dx));
      dl[1] = longint'($signed(a.dy));
      dl[2] = longint'($signed(a.dz));
      vl[0] = longint'($signed(a.vx));
      vl[1] = longint'($signed(a.vy));
      vl[2] = longint'($signed(a.vz));
      l0 = {33'd0, a.l0};
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        m = dl[i] < 0 ? -dl[i] : dl[i];
        sq += m * m;
      end
      r.fx = 0; r.fy = 0; r.fz = 0;
      if (a.op && sq > l0 * l0) begin
        r.st = sdlf_pkg::ST_NO_CONTACT;
        return r;
      end
      if (sq == 0) begin
        r.st = sdlf_pkg::ST_ZERO_DIST;
        return r;
      end
      dlen = isqrt(sq);
      sat = 0;
      for (int i = 0; i < 3; i++) begin
        q = (longint'(l0) * dl[i]) / longint'(dlen);
        t = dl[i] - q;
        m = t < 0 ? -t : t;
        wide = ({64'd0, m} * {96'd0, k_q}) >> FRAC;
        sm = (wide > (128'd1 << 50)) ? (64'd1 << 50) : wide[63:0];
        m = vl[i] < 0 ? -vl[i] : vl[i];
        dm = (m * {32'd0, z_q}) >> FRAC;
        sp = t < 0 ? -longint'(sm) : longint'(sm);
        dp = vl[i] < 0 ? -longint'(dm) : longint'(dm);
        f = sp - dp;
        if (f > 64'sd2147483647) begin
          f = 64'sd2147483647; sat = 1;
        end else if (f < -64'sd2147483648) begin
          f = -64'sd2147483648; sat = 1;
        end
        if (i == 0) r.fx = f[31:0];
        else if (i == 1) r.fy = f[31:0];
        else r.fz = f[31:0];
      end
      r.st = sat ? sdlf_pkg::ST_SAT : sdlf_pkg::ST_APPLIED;
      return r;
    endfunction

    function void note_link(link_t a);
      pending.push_back(link_force(a));
    endfunction

    function void check_force(logic [95:0] data, logic [1:0] st);
      force_t e;
      if (pending.size() == 0) begin
        $error("unexpected force item %h status %0d", data, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[31:0] !== e.fx) begin
        $error("force_x expected %h got %h", e.fx, data[31:0]); errors++;
      end
      if (data[63:32] !== e.fy) begin
        $error("force_y expected %h got %h", e.fy, data[63:32]); errors++;
      end
      if (data[95:64] !== e.fz) begin
        $error("force_z expected %h got %h", e.fz, data[95:64]); errors++;
      end
      if (st !== e.st) begin
        $error("status expected %0d got %0d", e.st, st); errors++;
      end
      matched++;
      status_seen[e.st]++;
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [sdlf_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic [sdlf_pkg::IN_TUSER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [sdlf_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [sdlf_pkg::OUT_TUSER_W-1:0] out_tuser;
  logic cfg_we = 0;
  logic cfg_addr = sdlf_pkg::REG_STIFFNESS;
  logic [31:0] cfg_wdata = '0;

  force_scoreboard sb = new();
  longint cycles = 0;
  int stall_mode = 0;  // 0 random, 1 always ready, 2 long hold-off
  int sent = 0;

  always #6 clk = ~clk;

  spring_damper_link_force #(.FRAC_BITS(FRAC)) i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_we, .cfg_addr, .cfg_wdata
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) sb.check_force(out_tdata, out_tuser);
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (stall_mode == 1) out_tready <= 1;
    else if (stall_mode == 2) out_tready <= 0;
    else out_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_link(link_t a);
    @(negedge clk);
    in_tvalid <= 1;
    in_tdata <= {1'b0, a.l0, a.vz, a.vy, a.vx, a.dz, a.dy, a.dx};
    in_tuser <= a.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_link(a);
    sent++;
  endtask

  task automatic idle_input(int n);
    @(negedge clk);
    in_tvalid <= 0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    idle_input(1);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    if (idx == sdlf_pkg::REG_STIFFNESS) sb.k_q = val;
    else sb.z_q = val;
  endtask

  function automatic logic [31:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'($signed($urandom_range(0, 8191)) - 4096);
      default: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
    endcase
  endfunction

  function automatic link_t rnd_link();
    link_t a;
    a.dx = rnd_comp(); a.dy = rnd_comp(); a.dz = rnd_comp();
    a.vx = rnd_comp(); a.vy = rnd_comp(); a.vz = rnd_comp();
    if ($urandom_range(0, 15) == 0) begin
      a.dx = 0; a.dy = 0; a.dz = 0;
    end
    case ($urandom_range(0, 3))
      0: a.l0 = 31'($urandom);
      1: a.l0 = 31'h7fff_ffff;
      default: a.l0 = 31'($urandom_range(0, 32'h0040_0000));
    endcase
    a.op = 1'($urandom_range(0, 1));
    return a;
  endfunction

  function automatic link_t mk(logic [31:0] dx, dy, dz, vx, vy, vz,
                               logic [30:0] l0, logic op);
    link_t a;
    a.dx = dx; a.dy = dy; a.dz = dz; a.vx = vx; a.vy = vy; a.vz = vz;
    a.l0 = l0; a.op = op;
    return a;
  endfunction

  task automatic random_phase(int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && n > 0; i++, n--) send_link(rnd_link());
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: reset constants, then extremes and each status case
    send_link(mk(32'h0001_0000, 0, 0, 0, 0, 0, 31'h0000_8000, 1'b0));
    send_link(mk(0, 0, 0, 32'h1234, 32'h5, 32'h6, 31'h10, 1'b0));
    send_link(mk(0, 0, 0, 0, 0, 0, 31'd0, 1'b1));
    send_link(mk(32'h0010_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 1'b1));
    send_link(mk(32'h0000_8000, 0, 0, 0, 0, 0, 31'h0001_0000, 1'b1));
    send_link(mk(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 31'h0005_0000, 1'b1));
    send_link(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff, 1'b0));
    send_link(mk(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff, 1'b1));
    send_link(mk(32'hffff_ffff, 1, 32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff,
                 31'd0, 1'b0));
    drain();

    write_reg(sdlf_pkg::REG_STIFFNESS, 32'hffff_ffff);
    write_reg(sdlf_pkg::REG_DAMPING, 32'hffff_ffff);
    send_link(mk(32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 0, 0, 31'd0, 1'b0));
    send_link(mk(32'h0001_0000, 32'hffff_0000, 1, 32'h8000_0000, 1, 32'hffff_ffff,
                 31'h0000_8000, 1'b0));
    send_link(mk(1, 0, 0, 0, 0, 0, 31'h7fff_ffff, 1'b0));
    drain();
    write_reg(sdlf_pkg::REG_STIFFNESS, 0);
    write_reg(sdlf_pkg::REG_DAMPING, 0);
    send_link(mk(32'h0002_0000, 32'h8000_0000, 3, 32'h7fff_ffff, 32'h8000_0000, 4,
                 31'h0001_0000, 1'b0));
    drain();

    // random phases across several constant settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(sdlf_pkg::REG_STIFFNESS, 32'h0001_0000);
          write_reg(sdlf_pkg::REG_DAMPING, 0);
        end
        1: begin
          write_reg(sdlf_pkg::REG_STIFFNESS, $urandom);
          write_reg(sdlf_pkg::REG_DAMPING, $urandom);
        end
        2: begin
          write_reg(sdlf_pkg::REG_STIFFNESS, 32'hffff_ffff);
          write_reg(sdlf_pkg::REG_DAMPING, 0);
        end
        3: begin
          write_reg(sdlf_pkg::REG_STIFFNESS, $urandom_range(0, 32'h0004_0000));
          write_reg(sdlf_pkg::REG_DAMPING, $urandom_range(0, 32'h0004_0000));
        end
        4: begin
          write_reg(sdlf_pkg::REG_STIFFNESS, 0);
          write_reg(sdlf_pkg::REG_DAMPING, 32'hffff_ffff);
        end
        default: begin
          write_reg(sdlf_pkg::REG_STIFFNESS, $urandom);
          write_reg(sdlf_pkg::REG_DAMPING, $urandom);
        end
      endcase
      stall_mode = (ph == 2) ? 1 : 0;
      if (ph == 3) begin
        // long receiver hold-off so the pipeline fills and backs up the input
        fork
          begin
            stall_mode = 2;
            for (int c = 0; c < 300; c++) @(posedge clk);
            stall_mode = 0;
          end
          random_phase(120);
        join
        random_phase(100);
      end else begin
        random_phase(250);
      end
      drain();
    end

    stall_mode = 1;
    drain();
    $display("sent %0d links, checked %0d forces over %0d cycles", sent, sb.matched, cycles);
    $display("status counts: applied %0d, no contact %0d, zero distance %0d, saturated %0d",
             sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.status_seen[3]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
